// ===== rtl/htfd_pkg.sv =====
// Shared types, constants and the byte-wide CRC-16 update for the
// humidity/temperature frame decoder. No dependencies.

package htfd_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] RAW_NAN  = 16'hFFFF;

	typedef logic [2:0] byte_pos_t;

	// Frame byte positions
	localparam byte_pos_t POS_FUNC   = 3'd0;
	localparam byte_pos_t POS_HUM_HI = 3'd2;
	localparam byte_pos_t POS_HUM_LO = 3'd3;
	localparam byte_pos_t POS_TMP_HI = 3'd4;
	localparam byte_pos_t POS_TMP_LO = 3'd5;
	localparam byte_pos_t POS_CRC_LO = 3'd6;
	localparam byte_pos_t POS_CRC_HI = 3'd7;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_CRC_ERR = 2'd1,
		STATUS_HUM_NAN = 2'd2,
		STATUS_TMP_NAN = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		status_t            status;
		logic [15:0]        humidity_tenths;
		logic signed [15:0] temperature_tenths;
	} out_item_t;

	// Reflected CRC-16, one byte, LSB first
	function automatic logic [15:0] crc_byte_update(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

// ===== rtl/htfd_result_fmt.sv =====
// Result formatting: CRC check, not-a-number checks and sign-magnitude
// conversion of the temperature. Depends on htfd_pkg.

module htfd_result_fmt (
	input  logic [15:0]        crc_calc,
	input  logic [15:0]        crc_rx,
	input  logic [15:0]        hum_raw,
	input  logic [15:0]        tmp_raw,
	output htfd_pkg::out_item_t result
);
	import htfd_pkg::*;

	logic [15:0] tmp_mag;

	assign tmp_mag = {1'b0, tmp_raw[14:0]};

	always_comb begin
		result.status             = STATUS_OK;
		result.humidity_tenths    = '0;
		result.temperature_tenths = '0;
		if (crc_rx != crc_calc) begin
			result.status = STATUS_CRC_ERR;
		end else if (hum_raw == RAW_NAN) begin
			result.status = STATUS_HUM_NAN;
		end else begin
			result.humidity_tenths = hum_raw;
			if (tmp_raw == RAW_NAN) begin
				result.status = STATUS_TMP_NAN;
			end else if (tmp_raw[15]) begin
				// negative zero comes out as plain zero
				result.temperature_tenths = 16'sd0 - $signed(tmp_mag);
			end else begin
				result.temperature_tenths = $signed(tmp_mag);
			end
		end
	end

endmodule

// ===== rtl/humidity_temp_frame_decoder.sv =====
// Humidity/temperature sensor response frame decoder, top level.
// Depends on htfd_pkg and htfd_result_fmt.

// Takes the 8-byte sensor response one byte per transfer, runs a reflected
// CRC-16 (init 0xFFFF, poly 0xA001) over bytes 0..5 and checks it against
// bytes 6 and 7 (low byte first), then emits one result after byte 7 with
// status (ok, CRC mismatch, humidity NaN, temperature NaN, first match
// wins), humidity in tenths and temperature in signed tenths. A byte with
// frame_start set restarts the frame and drops any partial one; after byte
// 7 the next byte is byte 0 anyway. The block accepts one byte per clock,
// but holds the last byte of a frame while the previous result waits. The
// rate is set by the combinational byte-wide CRC update between the input
// register and the frame state registers; the output register holds a
// result while later bytes of the next frame keep flowing in.

module humidity_temp_frame_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  htfd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output htfd_pkg::out_item_t out_data
);
	import htfd_pkg::*;

	// input register
	logic      valid_s1;
	in_item_t  item_s1;

	// frame state
	byte_pos_t   pos_q;
	logic [15:0] crc_q;
	logic [15:0] hum_raw_q;
	logic [15:0] tmp_raw_q;
	logic [7:0]  crc_lo_q;

	// output register
	logic      out_valid_q;
	out_item_t out_data_q;

	byte_pos_t   cur_pos;
	logic [15:0] cur_crc;
	logic        s1_last;
	logic        s1_go;
	out_item_t   result;

	assign cur_pos = item_s1.frame_start ? POS_FUNC : pos_q;
	assign cur_crc = item_s1.frame_start ? CRC_INIT : crc_q;
	assign s1_last = (cur_pos == POS_CRC_HI);
	// hold the last byte while the previous result is still waiting
	assign s1_go    = valid_s1 && (!s1_last || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;

	htfd_result_fmt u_fmt (
		.crc_calc (cur_crc),
		.crc_rx   ({item_s1.rx_byte, crc_lo_q}),
		.hum_raw  (hum_raw_q),
		.tmp_raw  (tmp_raw_q),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_FUNC;
			crc_q <= CRC_INIT;
		end else if (s1_go) begin
			pos_q <= cur_pos + 3'd1;
			if (s1_last) begin
				crc_q <= CRC_INIT;
			end else if (cur_pos < POS_CRC_LO) begin
				crc_q <= crc_byte_update(cur_crc, item_s1.rx_byte);
			end else begin
				crc_q <= cur_crc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			case (cur_pos)
				POS_HUM_HI: hum_raw_q[15:8] <= item_s1.rx_byte;
				POS_HUM_LO: hum_raw_q[7:0]  <= item_s1.rx_byte;
				POS_TMP_HI: tmp_raw_q[15:8] <= item_s1.rx_byte;
				POS_TMP_LO: tmp_raw_q[7:0]  <= item_s1.rx_byte;
				POS_CRC_LO: crc_lo_q        <= item_s1.rx_byte;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_last) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	// a new result never overwrites one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_go && s1_last && out_valid_q && !out_ready))
		else $error("result overwritten before transfer");

	// after the last byte the frame restarts at byte 0 with a fresh CRC
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && s1_last) |=> (pos_q == POS_FUNC && crc_q == CRC_INIT))
		else $error("frame state not restarted after last byte");

	// a CRC or humidity failure carries no measurement
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status == STATUS_CRC_ERR ||
			out_data.status == STATUS_HUM_NAN)) |->
		(out_data.humidity_tenths == 16'd0 && out_data.temperature_tenths == 16'sd0))
		else $error("measurement present with failing status");

	// an empty input register always takes a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while input register empty");
`endif

endmodule
